@@ rtl/slpc_pkg.sv @@
`default_nettype none
package slpc_pkg;

	// Field widths fixed by the block's interface.
	localparam int TIME_W  = 32;
	localparam int LEVEL_W = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 8;
	localparam int REQ_W   = 2;
	localparam int MODE_W  = 2;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SET     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_OVERLAY = 2'd2;

	// Mode codes.
	localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACTIVE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SUCCESS = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ERROR   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_HOLD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_HOLD   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_HOLD = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INT    = 8'd3;

	// Configuration reset values.
	localparam logic [CFG_W-1:0] RST_SUCCESS_HOLD = 16'd300;
	localparam logic [CFG_W-1:0] RST_ERROR_HOLD   = 16'd500;
	localparam logic [CFG_W-1:0] RST_OVERLAY_HOLD = 16'd500;
	localparam logic [CFG_W-1:0] RST_BLINK_INT    = 16'd50;

	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} pixel_t;

	// Pixel colors.
	localparam pixel_t COLOR_IDLE    = '{red: 16'h0000, green: 16'h0000, blue: 16'h0500};
	localparam pixel_t COLOR_SUCCESS = '{red: 16'h0000, green: 16'h0300, blue: 16'h0000};
	localparam pixel_t COLOR_ERROR   = '{red: 16'h0400, green: 16'h0000, blue: 16'h0000};
	localparam pixel_t COLOR_OVERLAY = '{red: 16'h0000, green: 16'h0300, blue: 16'h0500};
	localparam pixel_t COLOR_OV_REV  = '{red: 16'h0400, green: 16'h0000, blue: 16'h0500};
	localparam pixel_t COLOR_OFF     = '{red: 16'h0000, green: 16'h0000, blue: 16'h0000};

	// True when now is at or after the deadline, compared as a wrapping signed difference.
	function automatic logic time_reached(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] deadline);
		logic [TIME_W-1:0] diff;
		diff = now - deadline;
		return ~diff[TIME_W-1];
	endfunction

endpackage
`default_nettype wire

@@ rtl/slpc_if.sv @@
`default_nettype none
// Request channel into the controller.
interface slpc_req_if;
	import slpc_pkg::*;
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [TIME_W-1:0]   now_ms;
	logic [MODE_W-1:0]   new_mode;
	logic                overlay_reversed;
	logic                sink_ready;
	modport source(output valid, req_type, now_ms, new_mode, overlay_reversed, sink_ready,
		input ready);
	modport sink(input valid, req_type, now_ms, new_mode, overlay_reversed, sink_ready,
		output ready);
endinterface

// Pixel channel out of the controller.
interface slpc_pix_if;
	import slpc_pkg::*;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] red;
	logic [LEVEL_W-1:0] green;
	logic [LEVEL_W-1:0] blue;
	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

// Configuration write channel.
interface slpc_cfg_if;
	import slpc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/slpc_core.sv @@
`default_nettype none
module slpc_core (
	input  wire logic      clk,
	input  wire logic      arst_n,
	slpc_req_if.sink       req,
	slpc_cfg_if.sink       cfg,
	output logic           res_valid,
	output slpc_pkg::pixel_t res,
	input  wire logic      res_ready
);
	import slpc_pkg::*;

	// Input register.
	logic                valid_s1;
	logic [REQ_W-1:0]    req_type_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [MODE_W-1:0]   new_mode_s1;
	logic                rev_s1;
	logic                sink_ready_s1;
	logic                advance;

	// Configuration registers.
	logic [CFG_W-1:0] success_hold_q;
	logic [CFG_W-1:0] error_hold_q;
	logic [CFG_W-1:0] overlay_hold_q;
	logic [CFG_W-1:0] blink_int_q;

	// Display state and its next values.
	logic [MODE_W-1:0] mode_q, mode_d;
	logic              shown_q, shown_d;
	logic              blink_q, blink_d;
	logic              ov_act_q, ov_act_d;
	logic              ov_rev_q, ov_rev_d;
	logic [TIME_W-1:0] ov_dl_q, ov_dl_d;
	logic [TIME_W-1:0] rdl_q, rdl_d;
	logic [TIME_W-1:0] nft_q, nft_d;
	logic              emit;
	logic              cand;
	pixel_t            color;

	// The stored item moves on once the output buffer can take a result.
	assign advance   = valid_s1 && res_ready;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1   <= req.req_type;
			now_s1        <= req.now_ms;
			new_mode_s1   <= req.new_mode;
			rev_s1        <= req.overlay_reversed;
			sink_ready_s1 <= req.sink_ready;
		end
	end

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			success_hold_q <= RST_SUCCESS_HOLD;
			error_hold_q   <= RST_ERROR_HOLD;
			overlay_hold_q <= RST_OVERLAY_HOLD;
			blink_int_q    <= RST_BLINK_INT;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_SUCCESS_HOLD: success_hold_q <= cfg.data;
				CFG_ERROR_HOLD:   error_hold_q   <= cfg.data;
				CFG_OVERLAY_HOLD: overlay_hold_q <= cfg.data;
				CFG_BLINK_INT:    blink_int_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// One display step for the stored request.
	always_comb begin
		mode_d   = mode_q;
		shown_d  = shown_q;
		blink_d  = blink_q;
		ov_act_d = ov_act_q;
		ov_rev_d = ov_rev_q;
		ov_dl_d  = ov_dl_q;
		rdl_d    = rdl_q;
		nft_d    = nft_q;
		emit     = 1'b0;
		cand     = 1'b0;
		color    = COLOR_OFF;
		case (req_type_s1)
			REQ_TICK: begin
				// Expire the overlay first.
				if (ov_act_q && time_reached(now_s1, ov_dl_q)) begin
					ov_act_d = 1'b0;
					ov_rev_d = 1'b0;
					ov_dl_d  = '0;
					shown_d  = 1'b0;
					nft_d    = '0;
				end
				if (ov_act_d) begin
					if (!shown_d && sink_ready_s1) begin
						emit    = 1'b1;
						color   = ov_rev_d ? COLOR_OV_REV : COLOR_OVERLAY;
						shown_d = 1'b1;
					end
				end else begin
					// Success and error fall back to idle after their hold.
					if (mode_d != MODE_ACTIVE && rdl_d != '0 &&
							time_reached(now_s1, rdl_d)) begin
						mode_d  = MODE_IDLE;
						rdl_d   = '0;
						shown_d = 1'b0;
						nft_d   = '0;
					end
					case (mode_d)
						MODE_ACTIVE: begin
							cand  = time_reached(now_s1, nft_d);
							color = blink_q ? COLOR_IDLE : COLOR_OFF;
						end
						MODE_SUCCESS: begin
							cand  = !shown_d;
							color = COLOR_SUCCESS;
						end
						MODE_ERROR: begin
							cand  = !shown_d;
							color = COLOR_ERROR;
						end
						default: begin
							cand  = !shown_d;
							color = COLOR_IDLE;
						end
					endcase
					if (cand && sink_ready_s1) begin
						emit    = 1'b1;
						shown_d = 1'b1;
						if (mode_d == MODE_ACTIVE) begin
							blink_d = !blink_q;
							nft_d   = now_s1 + {{(TIME_W-CFG_W){1'b0}}, blink_int_q};
						end
					end
				end
			end
			REQ_SET: begin
				if (new_mode_s1 == mode_q) begin
					// A repeated success or error re-arms its hold.
					if (mode_q == MODE_SUCCESS) begin
						rdl_d = now_s1 + {{(TIME_W-CFG_W){1'b0}}, success_hold_q};
					end else if (mode_q == MODE_ERROR) begin
						rdl_d = now_s1 + {{(TIME_W-CFG_W){1'b0}}, error_hold_q};
					end
				end else begin
					mode_d  = new_mode_s1;
					shown_d = 1'b0;
					nft_d   = '0;
					case (new_mode_s1)
						MODE_ACTIVE: begin
							blink_d = 1'b1;
							rdl_d   = '0;
						end
						MODE_SUCCESS: rdl_d = now_s1 + {{(TIME_W-CFG_W){1'b0}}, success_hold_q};
						MODE_ERROR:   rdl_d = now_s1 + {{(TIME_W-CFG_W){1'b0}}, error_hold_q};
						default:      rdl_d = '0;
					endcase
				end
			end
			REQ_OVERLAY: begin
				ov_act_d = 1'b1;
				ov_rev_d = rev_s1;
				ov_dl_d  = now_s1 + {{(TIME_W-CFG_W){1'b0}}, overlay_hold_q};
				shown_d  = 1'b0;
			end
			default: ;
		endcase
	end

	// State is committed only when the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			shown_q  <= 1'b0;
			blink_q  <= 1'b1;
			ov_act_q <= 1'b0;
			ov_rev_q <= 1'b0;
			ov_dl_q  <= '0;
			rdl_q    <= '0;
			nft_q    <= '0;
		end else if (advance) begin
			mode_q   <= mode_d;
			shown_q  <= shown_d;
			blink_q  <= blink_d;
			ov_act_q <= ov_act_d;
			ov_rev_q <= ov_rev_d;
			ov_dl_q  <= ov_dl_d;
			rdl_q    <= rdl_d;
			nft_q    <= nft_d;
		end
	end

	assign res_valid = advance && emit;
	assign res       = color;

	// Only a tick produces a pixel.
	a_emit_tick: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (req_type_s1 == REQ_TICK))
		else $error("pixel produced by a non-tick request");

	// Active mode never carries a result deadline.
	a_active_no_dl: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_ACTIVE) |-> (rdl_q == '0))
		else $error("result deadline set in active mode");

	// An overlay request always leaves the overlay active.
	a_overlay_set: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_type_s1 == REQ_OVERLAY) |=> ov_act_q)
		else $error("overlay request did not arm the overlay");

	// A written pixel is marked as shown.
	a_shown_after: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> shown_q)
		else $error("pixel written but not marked shown");

endmodule
`default_nettype wire

@@ rtl/slpc_out.sv @@
`default_nettype none
module slpc_out (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire slpc_pkg::pixel_t in_pix,
	output logic                  in_ready,
	slpc_pix_if.source            pix
);
	import slpc_pkg::*;

	logic   valid_q;
	pixel_t pix_q;

	// The slot frees up in the same cycle that the sink takes the pixel.
	assign in_ready = !valid_q || pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pix_q <= in_pix;
		end
	end

	assign pix.valid = valid_q;
	assign pix.red   = pix_q.red;
	assign pix.green = pix_q.green;
	assign pix.blue  = pix_q.blue;

	// The core never offers a pixel the buffer cannot hold.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> in_ready)
		else $error("pixel offered while the output slot is full");

	// A new pixel is loaded only into a free or draining slot.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && valid_q) |-> pix.ready)
		else $error("pixel overwritten before it was taken");

	// A waiting pixel stays until the sink takes it.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pix.ready) |=> (valid_q && $stable(pix_q)))
		else $error("waiting pixel lost");

endmodule
`default_nettype wire

@@ rtl/status_led_pattern_controller_top.sv @@
// Status pixel pattern controller.
// The req channel takes timestamped requests: a tick, a set-mode request or a
// mux-status overlay request. The pix channel returns the pixel levels that a
// tick writes; most ticks write nothing, since a pixel goes out only when it
// changes and the tick says the pixel driver is ready. The cfg channel writes
// the four hold and blink registers and is always ready.
// Throughput is one request per cycle while the pix receiver does not stall. A
// request is held in the input register, where the display step runs against
// the stored state in a single pass; its pixel, if any, moves into the output
// register as the request leaves and appears on pix from there.
// When the pix receiver stalls, the pixel waits in the output register and one
// more request can still be accepted into the input register; further requests
// wait until the pixel is taken, so the state steps strictly in request order.
// Reset is asynchronous and active low: it clears both channels, sets the
// mode to idle with nothing shown and no overlay, and loads the registers with
// 300, 500, 500 and 50 ms.
`default_nettype none
module status_led_pattern_controller_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	slpc_req_if.sink   req,
	slpc_cfg_if.sink   cfg,
	slpc_pix_if.source pix
);
	import slpc_pkg::*;

	logic   res_valid;
	logic   res_ready;
	pixel_t res;

	slpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	slpc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_pix   (res),
		.in_ready (res_ready),
		.pix      (pix)
	);

endmodule
`default_nettype wire
